[sv/lasp_pkg.sv]
package lasp_pkg;

	// field widths at the ports
	localparam int FORMAT_KEY_W = 32;
	localparam int SLOT_W       = 4;
	localparam int USED_W       = 5;
	localparam int CAP_W        = 5;

	// defaults for the top-level parameters
	localparam int DEF_POOL_SLOTS = 16;
	localparam int DEF_KEY_BITS   = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam int STAMP_W = 32;

	typedef logic [FORMAT_KEY_W-1:0] format_key_t;
	typedef logic [SLOT_W-1:0]       slot_t;
	typedef logic [USED_W-1:0]       used_t;
	typedef logic [CAP_W-1:0]        cap_t;
	typedef logic [STAMP_W-1:0]      stamp_t;

endpackage

[sv/lru_associative_slot_pool.sv]
// channel   signals                                        direction
// request   in_valid, in_ready, format_key                 in
// result    out_valid, out_ready, slot, hit, evicted,      out
//           used_slots
// config    cfg_wr_en, cfg_wr_data (pool_capacity)         in
//
// A request is taken, compared against every slot in use, and decided before its
// result is registered; the pass over the slot memories is set by their single
// registered read port, one slot per cycle.
// The next request is taken in the cycle after the commit.
// After reset slot 0 holds key 0 with stamp 0; no clearing pass is needed.
// A finished result waits in the output register; the next request is taken
// meanwhile, and only its final commit waits for the output to free up.
module lru_associative_slot_pool #(
	parameter int POOL_SLOTS = lasp_pkg::DEF_POOL_SLOTS,
	parameter int KEY_BITS   = lasp_pkg::DEF_KEY_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  lasp_pkg::cap_t        cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lasp_pkg::format_key_t format_key,
	output logic                  out_valid,
	input  logic                  out_ready,
	output lasp_pkg::slot_t       slot,
	output logic                  hit,
	output logic                  evicted,
	output lasp_pkg::used_t       used_slots
);
	import lasp_pkg::*;

	localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int CNT_W = $clog2(POOL_SLOTS + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	state_t state_q;
	cap_t   cap_q;
	cnt_t   used_q;
	stamp_t counter_q;
	logic   slot0_ok_q;

	key_t   key_q;
	cnt_t   addr_q;
	logic   pv_q;
	idx_t   p_q;
	logic   found_q;
	idx_t   match_idx_q;
	stamp_t oldest_q;
	idx_t   old_idx_q;

	// slot memories
	key_t   key_mem [POOL_SLOTS];
	stamp_t stamp_mem [POOL_SLOTS];
	key_t   key_rd_q;
	stamp_t stamp_rd_q;
	logic   zero_rd_q;

	key_t   key_rd;
	stamp_t stamp_rd;
	key_t   key_in;
	logic   commit;
	logic   fill;
	idx_t   chosen;
	logic   [CMP_W-1:0] eff_cap;
	logic   last_rd;

	logic   out_valid_q;
	slot_t  slot_q;
	logic   hit_q;
	logic   evicted_q;
	used_t  used_slots_q;

	assign key_in = KEY_BITS'(format_key);

	// slot 0 reads as key 0, stamp 0 until first written after reset
	assign key_rd   = zero_rd_q ? '0 : key_rd_q;
	assign stamp_rd = zero_rd_q ? '0 : stamp_rd_q;

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CMP_W'(1);
		end else if (CMP_W'(cap_q) > CMP_W'(POOL_SLOTS)) begin
			eff_cap = CMP_W'(POOL_SLOTS);
		end else begin
			eff_cap = CMP_W'(cap_q);
		end
	end

	assign fill   = !found_q && (CMP_W'(used_q) < eff_cap);
	assign commit = (state_q == ST_DECIDE) && (!out_valid_q || out_ready);

	always_comb begin
		if (found_q) begin
			chosen = match_idx_q;
		end else if (fill) begin
			chosen = used_q[IDX_W-1:0];
		end else begin
			chosen = old_idx_q;
		end
	end

	assign last_rd = pv_q && ((CNT_W'(p_q) + CNT_W'(1)) == used_q);

	// on a hit the stored key equals key_q, so the key is always rewritten
	always_ff @(posedge clk) begin
		if (commit) begin
			key_mem[chosen]   <= key_q;
			stamp_mem[chosen] <= counter_q;
		end
		key_rd_q   <= key_mem[addr_q[IDX_W-1:0]];
		stamp_rd_q <= stamp_mem[addr_q[IDX_W-1:0]];
		zero_rd_q  <= (addr_q == '0) && !slot0_ok_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAP_RESET;
			used_q      <= CNT_W'(1);
			counter_q   <= STAMP_W'(1);
			slot0_ok_q  <= 1'b0;
			pv_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (out_valid_q && out_ready && !commit) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						key_q   <= key_in;
						addr_q  <= '0;
						pv_q    <= 1'b0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// issue one read a cycle, compare the previous one
					if (addr_q < used_q) begin
						pv_q   <= 1'b1;
						p_q    <= addr_q[IDX_W-1:0];
						addr_q <= addr_q + CNT_W'(1);
					end else begin
						pv_q <= 1'b0;
					end
					if (pv_q) begin
						if (!found_q && (key_rd == key_q)) begin
							found_q     <= 1'b1;
							match_idx_q <= p_q;
						end
						if ((p_q == '0) || (stamp_rd < oldest_q)) begin
							oldest_q  <= stamp_rd;
							old_idx_q <= p_q;
						end
					end
					if (last_rd) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (commit) begin
						if (fill) begin
							used_q <= used_q + CNT_W'(1);
						end
						if (chosen == '0) begin
							slot0_ok_q <= 1'b1;
						end
						counter_q    <= counter_q + STAMP_W'(1);
						out_valid_q  <= 1'b1;
						slot_q       <= SLOT_W'(chosen);
						hit_q        <= found_q;
						evicted_q    <= !found_q && !fill;
						used_slots_q <= fill ? USED_W'(used_q + CNT_W'(1)) : USED_W'(used_q);
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign slot       = slot_q;
	assign hit        = hit_q;
	assign evicted    = evicted_q;
	assign used_slots = used_slots_q;

endmodule
